// ===== rtl/core/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg
// Types, codes and defaults shared by the stable sorted queue cells and top.
// ----------------------------------------------------------------------------
package ssq_pkg;

	// field widths fixed by the command and result words
	localparam int KEY_BITS       = 8;
	localparam int PAY_FIELD_BITS = 32;

	// defaults for the top-level parameters
	localparam int DEPTH_DEF        = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	// command codes
	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_PUSHED    = 2'd0,
		ST_POPPED    = 2'd1,
		ST_POP_EMPTY = 2'd2,
		ST_PUSH_FULL = 2'd3
	} status_t;

	// command word
	typedef struct packed {
		cmd_t                         command;
		logic signed [KEY_BITS-1:0]   sort_key;
		logic [PAY_FIELD_BITS-1:0]    payload;
	} req_word_t;

	// result word
	typedef struct packed {
		status_t                      status;
		logic signed [KEY_BITS-1:0]   out_key;
		logic [PAY_FIELD_BITS-1:0]    out_payload;
	} rsp_word_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic                         push;
		logic                         pop;
		logic signed [KEY_BITS-1:0]   key;
	} cell_ctrl_t;

	// key and valid flag held by one cell
	typedef struct packed {
		logic                         valid;
		logic signed [KEY_BITS-1:0]   key;
	} cell_entry_t;

endpackage

// ===== rtl/core/ssq_cell.sv =====
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted chain: keeps, loads the new entry, or takes its
// neighbor's entry on push (from the left) or pop (from the right).
// ----------------------------------------------------------------------------
module ssq_cell #(
	parameter int STORE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ssq_pkg::cell_ctrl_t    ctrl,
	input  logic [STORE_BITS-1:0]  new_pay,
	input  ssq_pkg::cell_entry_t   prev_entry,
	input  logic [STORE_BITS-1:0]  prev_pay,
	input  logic                   prev_keep,
	input  ssq_pkg::cell_entry_t   next_entry,
	input  logic [STORE_BITS-1:0]  next_pay,
	output ssq_pkg::cell_entry_t   entry,
	output logic [STORE_BITS-1:0]  pay,
	output logic                   keep
);
	import ssq_pkg::*;

	logic                         valid_q;
	logic signed [KEY_BITS-1:0]   key_q;
	logic [STORE_BITS-1:0]        pay_q;

	// entry stays put on push when it is valid and its key is not above the new key
	assign keep = valid_q && (key_q <= ctrl.key);

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign pay         = pay_q;

	// valid flag: shifts right on push, left on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.push) begin
			valid_q <= prev_entry.valid;
		end else if (ctrl.pop) begin
			valid_q <= next_entry.valid;
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!keep) begin
				if (prev_keep) begin
					key_q <= ctrl.key;
					pay_q <= new_pay;
				end else begin
					key_q <= prev_entry.key;
					pay_q <= prev_pay;
				end
			end
		end else if (ctrl.pop) begin
			key_q <= next_entry.key;
			pay_q <= next_pay;
		end
	end

endmodule

// ===== rtl/core/stable_sorted_queue_unit.sv =====
// A command word taken at one edge gives its result word, marked by done,
// in the next cycle. Throughput: one command per cycle; busy stays low because
// every cell of the chain compares and shifts in the same cycle.
// Reset clears all valid flags, so the queue starts empty; slot data is not reset.
// Results cannot be held off and are shown for exactly one cycle.
// ----------------------------------------------------------------------------
// stable_sorted_queue_unit
// Stable priority queue on a chain of slot cells: push inserts behind all
// entries with keys not above its own, pop returns the head entry.
// ----------------------------------------------------------------------------
module stable_sorted_queue_unit #(
	parameter int DEPTH        = ssq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = ssq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ssq_pkg::req_word_t  request,
	output logic                done,
	output ssq_pkg::rsp_word_t  response
);
	import ssq_pkg::*;

	// payload bits actually kept per slot
	localparam int STORE_BITS = (PAYLOAD_BITS < PAY_FIELD_BITS) ? PAYLOAD_BITS
	                                                            : PAY_FIELD_BITS;

	cell_ctrl_t                  ctrl;
	logic [STORE_BITS-1:0]       new_pay;
	cell_entry_t                 entry  [DEPTH];
	logic [STORE_BITS-1:0]       pay    [DEPTH];
	logic                        keep   [DEPTH];
	logic                        full;
	logic                        empty;
	logic                        take;
	logic                        done_q;
	rsp_word_t                   rsp_q;

	assign busy    = 1'b0;
	assign take    = start && !busy;
	assign full    = entry[DEPTH-1].valid;
	assign empty   = !entry[0].valid;
	assign new_pay = request.payload[STORE_BITS-1:0];

	// command decode into the broadcast control
	always_comb begin
		ctrl.push = take && (request.command == CMD_PUSH) && !full;
		ctrl.pop  = take && (request.command == CMD_POP) && !empty;
		ctrl.key  = request.sort_key;
	end

	// chain of slot cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_entry_t             prev_e;
		logic [STORE_BITS-1:0]   prev_p;
		logic                    prev_k;
		cell_entry_t             next_e;
		logic [STORE_BITS-1:0]   next_p;

		if (i == 0) begin : g_head
			assign prev_e = '{valid: 1'b1, key: '0};
			assign prev_p = '0;
			assign prev_k = 1'b1;
		end else begin : g_body
			assign prev_e = entry[i-1];
			assign prev_p = pay[i-1];
			assign prev_k = keep[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign next_e = '{valid: 1'b0, key: '0};
			assign next_p = '0;
		end else begin : g_inner
			assign next_e = entry[i+1];
			assign next_p = pay[i+1];
		end

		ssq_cell #(
			.STORE_BITS (STORE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_pay    (new_pay),
			.prev_entry (prev_e),
			.prev_pay   (prev_p),
			.prev_keep  (prev_k),
			.next_entry (next_e),
			.next_pay   (next_p),
			.entry      (entry[i]),
			.pay        (pay[i]),
			.keep       (keep[i])
		);
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= take;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (take) begin
			unique case (request.command)
				CMD_PUSH: begin
					rsp_q.status      <= full ? ST_PUSH_FULL : ST_PUSHED;
					rsp_q.out_key     <= '0;
					rsp_q.out_payload <= '0;
				end
				CMD_POP: begin
					if (empty) begin
						rsp_q.status      <= ST_POP_EMPTY;
						rsp_q.out_key     <= '0;
						rsp_q.out_payload <= '0;
					end else begin
						rsp_q.status      <= ST_POPPED;
						rsp_q.out_key     <= entry[0].key;
						rsp_q.out_payload <= PAY_FIELD_BITS'(pay[0]);
					end
				end
				default: begin
					rsp_q.status      <= ST_POP_EMPTY;
					rsp_q.out_key     <= '0;
					rsp_q.out_payload <= '0;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign response = rsp_q;

endmodule

// ===== bench/stable_sorted_queue_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_sorted_queue_unit_test
// Self-checking bench for the stable sorted queue. Push and pop words go in
// through the start/busy handshake. A shadow copy of the sorted slots predicts
// each result word, and every done strobe is compared field by field.
// ----------------------------------------------------------------------------
module stable_sorted_queue_unit_test;
	import ssq_pkg::*;

	localparam int SLOTS    = DEPTH_DEF;
	localparam int PAY_BITS = PAYLOAD_BITS_DEF;
	localparam logic [PAY_FIELD_BITS-1:0] PAY_MASK =
		(PAY_BITS >= PAY_FIELD_BITS) ? '1 : ((PAY_FIELD_BITS'(1) << PAY_BITS) - 1);

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       done;
	req_word_t  request;
	rsp_word_t  response;

	// shadow of the sorted slot chain
	logic signed [KEY_BITS-1:0]   shadow_key [SLOTS];
	logic [PAY_FIELD_BITS-1:0]    shadow_pay [SLOTS];
	int                           shadow_fill;

	rsp_word_t  replies_due [$];
	rsp_word_t  oldest_reply;
	int         error_count;
	int         status_tally [4];

	stable_sorted_queue_unit #(
		.DEPTH        (SLOTS),
		.PAYLOAD_BITS (PAY_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// apply one word to the shadow queue and return the result word it gives
	function automatic rsp_word_t queue_reply(req_word_t w);
		rsp_word_t r;
		int        pos;
		int        i;
		r = '0;
		if (w.command == CMD_PUSH) begin
			if (shadow_fill >= SLOTS) begin
				r.status = ST_PUSH_FULL;
			end else begin
				// new entry goes behind every entry with a key not above its own
				pos = 0;
				while (pos < shadow_fill && $signed(shadow_key[pos]) <= $signed(w.sort_key))
					pos++;
				for (i = shadow_fill; i > pos; i--) begin
					shadow_key[i] = shadow_key[i-1];
					shadow_pay[i] = shadow_pay[i-1];
				end
				shadow_key[pos] = w.sort_key;
				shadow_pay[pos] = w.payload & PAY_MASK;
				shadow_fill++;
				r.status = ST_PUSHED;
			end
		end else if (shadow_fill == 0) begin
			r.status = ST_POP_EMPTY;
		end else begin
			r.status      = ST_POPPED;
			r.out_key     = shadow_key[0];
			r.out_payload = shadow_pay[0];
			for (i = 0; i + 1 < shadow_fill; i++) begin
				shadow_key[i] = shadow_key[i+1];
				shadow_pay[i] = shadow_pay[i+1];
			end
			shadow_fill--;
		end
		return r;
	endfunction

	// drive one word and hold it until the block takes it
	task automatic send_word(cmd_t c, logic signed [KEY_BITS-1:0] k,
			logic [PAY_FIELD_BITS-1:0] p);
		req_word_t w;
		w.command  = c;
		w.sort_key = k;
		w.payload  = p;
		@(negedge clk);
		start   <= 1'b1;
		request <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		replies_due.push_back(queue_reply(w));
	endtask

	// sender gap with junk on the request bus
	task automatic idle_burst(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start   <= 1'b0;
			request <= $bits(req_word_t)'({$urandom(), $urandom()});
		end
	endtask

	// stop sending and wait for every outstanding result word
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	// random word, push share in percent; keys often collide on purpose
	task automatic send_random(int push_pct);
		cmd_t                       c;
		logic signed [KEY_BITS-1:0] k;
		c = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
		case ($urandom_range(0, 3))
			0: k = KEY_BITS'(int'($urandom_range(0, 4)) - 2);
			1: k = $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
			default: k = KEY_BITS'($urandom_range(0, 255));
		endcase
		send_word(c, k, $urandom());
	endtask

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				error_count++;
				$display("%0t: result with none due, got status %0d key %0d payload %h",
					$time, response.status, response.out_key, response.out_payload);
			end else begin
				oldest_reply = replies_due.pop_front();
				if (response.status !== oldest_reply.status) begin
					error_count++;
					$display("%0t: status expected %0d got %0d",
						$time, oldest_reply.status, response.status);
				end
				if (response.out_key !== oldest_reply.out_key) begin
					error_count++;
					$display("%0t: out_key expected %0d got %0d",
						$time, oldest_reply.out_key, response.out_key);
				end
				if (response.out_payload !== oldest_reply.out_payload) begin
					error_count++;
					$display("%0t: out_payload expected %h got %h",
						$time, oldest_reply.out_payload, response.out_payload);
				end
				status_tally[oldest_reply.status]++;
			end
		end
	end

	// empty pop, extreme keys and payloads, equal keys, full queue, ordered pops
	task automatic test_directed_cases();
		byte                       dir_key [16] = '{-128, 127, 0, 0, 0, -1, 1, 127,
		                                            -128, 5, 5, -5, 100, -100, 64, -64};
		logic [PAY_FIELD_BITS-1:0] dir_pay [4]  = '{32'h0000_0000, 32'hffff_ffff,
		                                            32'h5555_5555, 32'haaaa_aaaa};
		int                        i;
		send_word(CMD_POP, 8'sh55, 32'hdead_beef);
		for (i = 0; i < SLOTS; i++)
			send_word(CMD_PUSH, dir_key[i % 16], dir_pay[i % 4] ^ i);
		send_word(CMD_PUSH, 8'sh80, 32'h8000_0000);
		repeat (6)
			send_word(CMD_POP, 8'sh7f, 32'hffff_ffff);
	endtask

	// sender holds off until the queue has answered everything
	task automatic test_pause_until_drained();
		repeat (3) begin
			repeat ($urandom_range(5, 12))
				send_random(60);
			wait_drained();
		end
	endtask

	// fill, drain and mixed episodes with random sender gaps
	task automatic test_random_traffic(int word_total);
		int sent;
		int len;
		int push_pct;
		bit quiet;
		sent = 0;
		while (sent < word_total) begin
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			len   = $urandom_range(8, 40);
			quiet = ($urandom_range(0, 3) == 0);
			repeat (len) begin
				if (!quiet && $urandom_range(0, 5) == 0)
					idle_burst($urandom_range(1, 19));
				send_random(push_pct);
				sent++;
			end
		end
	endtask

	// closing stretch with a word every cycle
	task automatic test_back_to_back(int word_total);
		repeat (word_total)
			send_random(50);
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		shadow_fill = 0;
		error_count = 0;
		status_tally = '{0, 0, 0, 0};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_pause_until_drained();
		test_random_traffic(620);
		test_back_to_back(60);

		// let the last result words arrive, then watch for stray strobes
		wait_drained();
		repeat (4) @(posedge clk);

		$display("covered %0d pushes, %0d pops with data, %0d pops on empty, %0d full refusals",
			status_tally[ST_PUSHED], status_tally[ST_POPPED],
			status_tally[ST_POP_EMPTY], status_tally[ST_PUSH_FULL]);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hang guard
	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ssq_pkg.sv
rtl/core/ssq_cell.sv
rtl/core/stable_sorted_queue_unit.sv
bench/stable_sorted_queue_unit_test.sv
